@@ rtl/spfa_pkg.sv @@
// Shared types, constants and command encodings of the port allocator.
`default_nettype none

package spfa_pkg;

	localparam int PORT_W         = 16;
	localparam int STATUS_W       = 2;
	localparam int CFG_IDX_W      = 2;
	localparam int FREE_DEPTH_DEF = 1024;

	localparam logic [PORT_W-1:0] FIRST_PORT_RESET = 16'd1024;
	localparam logic [PORT_W-1:0] PORT_LIMIT_RESET = 16'd65535;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_PORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PORT_LIMIT = 2'd1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd3;

	localparam logic OP_ALLOCATE = 1'b0;
	localparam logic OP_RELEASE  = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [PORT_W-1:0] freed_port;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0]   port_number;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		RD_NONE, RD_ZERO, RD_PARENT, RD_CNT, RD_CHILD, RD_CHILD1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE, WR_VAL, WR_RDATA, WR_CVAL
	} wr_sel_t;

	typedef enum logic [2:0] {
		IDX_KEEP, IDX_PARENT, IDX_ZERO, IDX_CNT, IDX_CIDX
	} idx_sel_t;

	typedef enum logic [2:0] {
		RES_KEEP, RES_RELEASED, RES_FULL, RES_EXH, RES_FRESH, RES_TOP
	} res_sel_t;

	typedef enum logic [1:0] {
		CNT_KEEP, CNT_INC, CNT_DEC
	} cnt_op_t;

	typedef enum logic [1:0] {
		VAL_KEEP, VAL_IN, VAL_RD
	} val_sel_t;

	typedef struct packed {
		rd_sel_t  rd_sel;
		wr_sel_t  wr_sel;
		idx_sel_t idx_sel;
		res_sel_t res_sel;
		cnt_op_t  cnt_op;
		val_sel_t val_sel;
		logic     cval_c;
		logic     cval_c1;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_full;
		logic fresh_exh;
		logic idx_zero;
		logic rd_le_val;
		logic c_ge_cnt;
		logic c1_lt_cnt;
		logic rd_lt_cval;
		logic val_le_cval;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/smallest_free_port_allocator.sv @@
// Top level of the smallest-free port allocator: controller, datapath and heap RAM.
//
//   port      dir   word     handshake
//   in_*      in    req_t    in_valid / in_ready
//   out_*     out   rsp_t    out_valid / out_ready
//   cfg_*     in    16 bit   cfg_we, no wait
//
// One request at a time; in_ready is high only while the controller is idle.
// Allocate from watermark, exhausted and list-full words go from idle straight to finish.
// Release sifts the new port up from the new last slot, moving larger parents down.
// Allocate from the heap returns the root and sifts the last entry down from the top,
// taking the smaller child. A waiting result holds the finish only, not acceptance.
// Reset clears the count and loads first_port and port_limit defaults; the heap is not cleared.
`default_nettype none

module smallest_free_port_allocator #(
	parameter int FREE_DEPTH = spfa_pkg::FREE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire spfa_pkg::req_t                 in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output spfa_pkg::rsp_t                      out_data,
	input  wire logic                           cfg_we,
	input  wire logic [spfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spfa_pkg::PORT_W-1:0]    cfg_data
);

	spfa_pkg::cmd_t    cmd;
	spfa_pkg::status_t status;

	spfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_op   (in_data.operation),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	spfa_dp #(
		.FREE_DEPTH(FREE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.freed_port(in_data.freed_port),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire

@@ rtl/spfa_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module spfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/spfa_dp.sv @@
// Datapath: heap memory, count, watermark, limit and the result register.
`default_nettype none

module spfa_dp #(
	parameter int FREE_DEPTH = spfa_pkg::FREE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire spfa_pkg::cmd_t                 cmd,
	output spfa_pkg::status_t                   status,
	input  wire logic [spfa_pkg::PORT_W-1:0]    freed_port,
	input  wire logic                           cfg_we,
	input  wire logic [spfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spfa_pkg::PORT_W-1:0]    cfg_data,
	output spfa_pkg::rsp_t                      out_data,
	output logic                                out_valid,
	input  wire logic                           out_ready
);

	localparam int AW = $clog2(FREE_DEPTH);
	localparam int CW = $clog2(FREE_DEPTH + 1);

	logic [AW-1:0]                 idx_q, cidx_q;
	logic [CW-1:0]                 cnt_q;
	logic [spfa_pkg::PORT_W-1:0]   val_q, cval_q, fresh_q, limit_q;
	spfa_pkg::rsp_t                res_q, out_q;
	logic                          out_valid_q;

	logic [AW-1:0]                 parent;
	logic [AW:0]                   child, child1, cnt_x;
	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [spfa_pkg::PORT_W-1:0]   ram_wdata, rdata;

	assign parent = (idx_q - AW'(1)) >> 1;
	assign child  = {idx_q, 1'b1};
	assign child1 = {idx_q, 1'b0} + (AW+1)'(2);
	assign cnt_x  = (AW+1)'(cnt_q);

	always_comb begin
		ram_re    = (cmd.rd_sel != spfa_pkg::RD_NONE);
		ram_raddr = '0;
		case (cmd.rd_sel)
			spfa_pkg::RD_PARENT: ram_raddr = parent;
			spfa_pkg::RD_CNT:    ram_raddr = cnt_q[AW-1:0];
			spfa_pkg::RD_CHILD:  ram_raddr = child[AW-1:0];
			spfa_pkg::RD_CHILD1: ram_raddr = child1[AW-1:0];
			default:             ram_raddr = '0;
		endcase
	end

	always_comb begin
		ram_we    = (cmd.wr_sel != spfa_pkg::WR_NONE);
		ram_wdata = val_q;
		case (cmd.wr_sel)
			spfa_pkg::WR_RDATA: ram_wdata = rdata;
			spfa_pkg::WR_CVAL:  ram_wdata = cval_q;
			default:            ram_wdata = val_q;
		endcase
	end

	spfa_ram #(
		.WIDTH(spfa_pkg::PORT_W),
		.DEPTH(FREE_DEPTH)
	) u_heap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	// sift registers: no reset needed
	always_ff @(posedge clk) begin
		case (cmd.idx_sel)
			spfa_pkg::IDX_PARENT: idx_q <= parent;
			spfa_pkg::IDX_ZERO:   idx_q <= '0;
			spfa_pkg::IDX_CNT:    idx_q <= cnt_q[AW-1:0];
			spfa_pkg::IDX_CIDX:   idx_q <= cidx_q;
			default:              idx_q <= idx_q;
		endcase
		case (cmd.val_sel)
			spfa_pkg::VAL_IN: val_q <= freed_port;
			spfa_pkg::VAL_RD: val_q <= rdata;
			default:          val_q <= val_q;
		endcase
		if (cmd.cval_c) begin
			cval_q <= rdata;
			cidx_q <= child[AW-1:0];
		end else if (cmd.cval_c1) begin
			cval_q <= rdata;
			cidx_q <= child1[AW-1:0];
		end
		case (cmd.res_sel)
			spfa_pkg::RES_RELEASED: res_q <= '{'0, spfa_pkg::ST_RELEASED};
			spfa_pkg::RES_FULL:     res_q <= '{'0, spfa_pkg::ST_LIST_FULL};
			spfa_pkg::RES_EXH:      res_q <= '{'0, spfa_pkg::ST_EXHAUSTED};
			spfa_pkg::RES_FRESH:    res_q <= '{fresh_q, spfa_pkg::ST_ALLOCATED};
			spfa_pkg::RES_TOP:      res_q <= '{rdata, spfa_pkg::ST_ALLOCATED};
			default:                res_q <= res_q;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			fresh_q     <= spfa_pkg::FIRST_PORT_RESET;
			limit_q     <= spfa_pkg::PORT_LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				spfa_pkg::CNT_INC: cnt_q <= cnt_q + CW'(1);
				spfa_pkg::CNT_DEC: cnt_q <= cnt_q - CW'(1);
				default:           cnt_q <= cnt_q;
			endcase
			// writes to first_port reload the watermark
			if (cfg_we && cfg_index == spfa_pkg::REG_FIRST_PORT) begin
				fresh_q <= cfg_data;
			end else if (cmd.res_sel == spfa_pkg::RES_FRESH) begin
				fresh_q <= fresh_q + spfa_pkg::PORT_W'(1);
			end
			if (cfg_we && cfg_index == spfa_pkg::REG_PORT_LIMIT) begin
				limit_q <= cfg_data;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.cnt_zero    = (cnt_q == '0);
	assign status.cnt_full    = (cnt_q == CW'(FREE_DEPTH));
	assign status.fresh_exh   = (fresh_q >= limit_q);
	assign status.idx_zero    = (idx_q == '0);
	assign status.rd_le_val   = (rdata <= val_q);
	assign status.c_ge_cnt    = (child >= cnt_x);
	assign status.c1_lt_cnt   = (child1 < cnt_x);
	assign status.rd_lt_cval  = (rdata < cval_q);
	assign status.val_le_cval = (val_q <= cval_q);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FREE_DEPTH))
		else $error("free count above heap depth");

	load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while full");

endmodule

`default_nettype wire

@@ rtl/spfa_ctrl.sv @@
// Controller: request decode and heap sift sequencing.
`default_nettype none

module spfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_op,
	output logic                   in_ready,
	input  wire spfa_pkg::status_t status,
	output spfa_pkg::cmd_t         cmd
);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_PUSH_UP  = 10'b00_0000_0010,
		S_PUSH_CMP = 10'b00_0000_0100,
		S_POP_TOP  = 10'b00_0000_1000,
		S_POP_LAST = 10'b00_0001_0000,
		S_DN_RD    = 10'b00_0010_0000,
		S_DN_C0    = 10'b00_0100_0000,
		S_DN_C1    = 10'b00_1000_0000,
		S_DN_CMP   = 10'b01_0000_0000,
		S_FINISH   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == spfa_pkg::OP_RELEASE) begin
						if (status.cnt_full) begin
							cmd.res_sel = spfa_pkg::RES_FULL;
							state_d     = S_FINISH;
						end else begin
							cmd.res_sel = spfa_pkg::RES_RELEASED;
							cmd.val_sel = spfa_pkg::VAL_IN;
							cmd.idx_sel = spfa_pkg::IDX_CNT;
							cmd.cnt_op  = spfa_pkg::CNT_INC;
							state_d     = S_PUSH_UP;
						end
					end else if (!status.cnt_zero) begin
						cmd.cnt_op  = spfa_pkg::CNT_DEC;
						cmd.idx_sel = spfa_pkg::IDX_ZERO;
						cmd.rd_sel  = spfa_pkg::RD_ZERO;
						state_d     = S_POP_TOP;
					end else if (status.fresh_exh) begin
						cmd.res_sel = spfa_pkg::RES_EXH;
						state_d     = S_FINISH;
					end else begin
						cmd.res_sel = spfa_pkg::RES_FRESH;
						state_d     = S_FINISH;
					end
				end
			end
			S_PUSH_UP: begin
				if (status.idx_zero) begin
					cmd.wr_sel = spfa_pkg::WR_VAL;
					state_d    = S_FINISH;
				end else begin
					cmd.rd_sel = spfa_pkg::RD_PARENT;
					state_d    = S_PUSH_CMP;
				end
			end
			S_PUSH_CMP: begin
				if (status.rd_le_val) begin
					cmd.wr_sel = spfa_pkg::WR_VAL;
					state_d    = S_FINISH;
				end else begin
					// parent moves down a level
					cmd.wr_sel  = spfa_pkg::WR_RDATA;
					cmd.idx_sel = spfa_pkg::IDX_PARENT;
					state_d     = S_PUSH_UP;
				end
			end
			S_POP_TOP: begin
				cmd.res_sel = spfa_pkg::RES_TOP;
				cmd.rd_sel  = spfa_pkg::RD_CNT;
				state_d     = S_POP_LAST;
			end
			S_POP_LAST: begin
				cmd.val_sel = spfa_pkg::VAL_RD;
				state_d     = S_DN_RD;
			end
			S_DN_RD: begin
				if (status.c_ge_cnt) begin
					if (!status.cnt_zero) begin
						cmd.wr_sel = spfa_pkg::WR_VAL;
					end
					state_d = S_FINISH;
				end else begin
					cmd.rd_sel = spfa_pkg::RD_CHILD;
					state_d    = S_DN_C0;
				end
			end
			S_DN_C0: begin
				cmd.cval_c = 1'b1;
				if (status.c1_lt_cnt) begin
					cmd.rd_sel = spfa_pkg::RD_CHILD1;
					state_d    = S_DN_C1;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_C1: begin
				cmd.cval_c1 = status.rd_lt_cval;
				state_d     = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (status.val_le_cval) begin
					cmd.wr_sel = spfa_pkg::WR_VAL;
					state_d    = S_FINISH;
				end else begin
					cmd.wr_sel  = spfa_pkg::WR_CVAL;
					cmd.idx_sel = spfa_pkg::IDX_CIDX;
					state_d     = S_DN_RD;
				end
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while a request is in flight");

	finish_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH && status.out_free |=> in_ready)
		else $error("controller did not return to idle after loading result");

	pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_op == spfa_pkg::CNT_DEC |-> !status.cnt_zero)
		else $error("pop issued on empty free list");

	fresh_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_sel == spfa_pkg::RES_FRESH |-> !status.fresh_exh && status.cnt_zero)
		else $error("fresh port handed out past the limit or with free entries");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the port allocator: directed and random words against a port pool model.
`timescale 1ns / 1ps

module tb_top;

	localparam int POOL_DEPTH     = spfa_pkg::FREE_DEPTH_DEF;
	localparam int STALL_MAX      = 11;
	localparam int SETTLE_CYCLES  = 60;    // idle margin after the last expected word
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [spfa_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [spfa_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	class port_pool_model;
		logic [spfa_pkg::PORT_W-1:0] first_port;
		logic [spfa_pkg::PORT_W-1:0] port_limit;
		logic [spfa_pkg::PORT_W-1:0] next_fresh;
		logic [spfa_pkg::PORT_W-1:0] free_ports[$];    // ascending, so the front is the smallest
		logic [spfa_pkg::PORT_W-1:0] handed_out[$];    // recent grants, reused as realistic releases
		spfa_pkg::rsp_t              expected_words[$];
		int                          mismatches;

		function new();
			first_port = spfa_pkg::FIRST_PORT_RESET;
			port_limit = spfa_pkg::PORT_LIMIT_RESET;
			next_fresh = spfa_pkg::FIRST_PORT_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [spfa_pkg::CFG_IDX_W-1:0] index,
				logic [spfa_pkg::PORT_W-1:0] value);
			case (index)
				spfa_pkg::REG_FIRST_PORT: begin
					first_port = value;
					next_fresh = value;
				end
				spfa_pkg::REG_PORT_LIMIT: port_limit = value;
				default: ;
			endcase
		endfunction

		function void note_request(spfa_pkg::req_t req);
			spfa_pkg::rsp_t word;
			int             pos;
			word.port_number = '0;
			word.status      = spfa_pkg::ST_ALLOCATED;
			if (req.operation == spfa_pkg::OP_RELEASE) begin
				if (free_ports.size() >= POOL_DEPTH) begin
					word.status = spfa_pkg::ST_LIST_FULL;
				end else begin
					pos = 0;
					while (pos < free_ports.size() && free_ports[pos] <= req.freed_port)
						pos++;
					free_ports.insert(pos, req.freed_port);
					word.status = spfa_pkg::ST_RELEASED;
				end
			end else if (free_ports.size() != 0) begin
				word.port_number = free_ports.pop_front();
			end else if (next_fresh >= port_limit) begin
				word.status = spfa_pkg::ST_EXHAUSTED;
			end else begin
				word.port_number = next_fresh;
				next_fresh++;
			end
			if (word.status == spfa_pkg::ST_ALLOCATED) begin
				handed_out = {handed_out, word.port_number};
				if (handed_out.size() > 256)
					void'(handed_out.pop_front());
			end
			expected_words = {expected_words, word};
		endfunction

		function void flag(string what, logic [spfa_pkg::PORT_W-1:0] want,
				logic [spfa_pkg::PORT_W-1:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
		endfunction

		function void check_response(spfa_pkg::rsp_t got);
			spfa_pkg::rsp_t want;
			if (expected_words.size() == 0) begin
				flag("unexpected word", '0, got.port_number);
				return;
			end
			want = expected_words.pop_front();
			if (got.port_number !== want.port_number)
				flag("port_number", want.port_number, got.port_number);
			if (got.status !== want.status)
				flag("status", spfa_pkg::PORT_W'(want.status), spfa_pkg::PORT_W'(got.status));
		endfunction
	endclass

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	spfa_pkg::req_t                 in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	spfa_pkg::rsp_t                 out_data;
	logic                           cfg_we    = 1'b0;
	logic [spfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [spfa_pkg::PORT_W-1:0]    cfg_data  = '0;

	port_pool_model pool;
	bit             tx_gaps = 1'b1;
	bit             rx_gaps = 1'b1;
	int             rx_hold = 0;
	int             rx_draw;
	int             idle_cycles = 0;

	smallest_free_port_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result side: random stall after each accepted word, checked on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold   <= 0;
		end else if (out_valid && out_ready) begin
			pool.check_response(out_data);
			rx_draw = rx_gaps ? int'($urandom_range(0, STALL_MAX)) : 0;
			rx_hold   <= rx_draw;
			out_ready <= (rx_draw == 0);
		end else if (rx_hold != 0) begin
			rx_hold   <= rx_hold - 1;
			out_ready <= (rx_hold == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic op, input logic [spfa_pkg::PORT_W-1:0] port);
		spfa_pkg::req_t req;
		int             gap;
		req.operation  = op;
		req.freed_port = port;
		gap = tx_gaps ? int'($urandom_range(0, STALL_MAX)) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		pool.note_request(req);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pool.expected_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called with the allocator idle
	task automatic configure(input logic [spfa_pkg::PORT_W-1:0] first_val,
			input logic [spfa_pkg::PORT_W-1:0] limit_val);
		logic [spfa_pkg::PORT_W-1:0] junk;
		junk = spfa_pkg::PORT_W'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SPARE_A;
		cfg_data  <= junk;
		pool.write_reg(REG_SPARE_A, junk);
		@(posedge clk);
		cfg_index <= spfa_pkg::REG_PORT_LIMIT;
		cfg_data  <= limit_val;
		pool.write_reg(spfa_pkg::REG_PORT_LIMIT, limit_val);
		@(posedge clk);
		cfg_index <= spfa_pkg::REG_FIRST_PORT;
		cfg_data  <= first_val;
		pool.write_reg(spfa_pkg::REG_FIRST_PORT, first_val);
		@(posedge clk);
		cfg_index <= REG_SPARE_B;
		cfg_data  <= ~junk;
		pool.write_reg(REG_SPARE_B, ~junk);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [spfa_pkg::PORT_W-1:0] pick_port();
		int                          sel;
		int                          idx;
		logic [spfa_pkg::PORT_W-1:0] p;
		sel = $urandom_range(0, 9);
		if (sel < 4 && pool.handed_out.size() != 0) begin
			idx = $urandom_range(0, pool.handed_out.size() - 1);
			p = pool.handed_out[idx];
			pool.handed_out.delete(idx);
		end else if (sel < 6) begin
			case ($urandom_range(0, 3))
				0: p = '0;
				1: p = '1;
				2: p = spfa_pkg::PORT_W'(1) << $urandom_range(0, spfa_pkg::PORT_W - 1);
				default: p = ~(spfa_pkg::PORT_W'(1) << $urandom_range(0, spfa_pkg::PORT_W - 1));
			endcase
		end else begin
			p = spfa_pkg::PORT_W'($urandom);
		end
		return p;
	endfunction

	task automatic random_phase(input int n_items, input int release_pct);
		logic                        op;
		logic [spfa_pkg::PORT_W-1:0] f;
		logic [spfa_pkg::PORT_W-1:0] l;
		case ($urandom_range(0, 3))
			0: begin
				f = '0;
				l = '1;
			end
			1: begin
				// tight window so the watermark runs out
				f = spfa_pkg::PORT_W'($urandom);
				l = (f > 16'hFFD7) ? 16'hFFFF : f + spfa_pkg::PORT_W'($urandom_range(0, 40));
			end
			2: begin
				l = spfa_pkg::PORT_W'($urandom_range(0, 16'hFFFE));
				f = spfa_pkg::PORT_W'($urandom_range(l, 16'hFFFF));
			end
			default: begin
				f = spfa_pkg::PORT_W'($urandom);
				l = spfa_pkg::PORT_W'($urandom);
			end
		endcase
		configure(f, l);
		for (int k = 0; k < n_items; k++) begin
			op = ($urandom_range(0, 99) < release_pct) ? spfa_pkg::OP_RELEASE
				: spfa_pkg::OP_ALLOCATE;
			if ($urandom_range(0, 99) == 0)
				wait_idle();
			send_request(op, pick_port());
		end
		wait_idle();
	endtask

	initial begin
		int n_fill;
		int pcts[5];
		pool = new();
		pcts = '{25, 50, 75, 50, 60};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: fresh grant, extremes, duplicate release, heap order
		send_request(spfa_pkg::OP_ALLOCATE, 16'h0000);
		send_request(spfa_pkg::OP_RELEASE, 16'h0000);
		send_request(spfa_pkg::OP_RELEASE, 16'hFFFF);
		send_request(spfa_pkg::OP_RELEASE, 16'hAAAA);
		send_request(spfa_pkg::OP_RELEASE, 16'h5555);
		send_request(spfa_pkg::OP_RELEASE, 16'd1024);
		send_request(spfa_pkg::OP_RELEASE, 16'd1024);
		repeat (7) send_request(spfa_pkg::OP_ALLOCATE, 16'hFFFF);
		wait_idle();

		// watermark at the ceiling
		configure(16'hFFFE, 16'hFFFF);
		send_request(spfa_pkg::OP_ALLOCATE, 16'h1234);
		send_request(spfa_pkg::OP_ALLOCATE, 16'h0000);
		send_request(spfa_pkg::OP_RELEASE, 16'd7);
		send_request(spfa_pkg::OP_ALLOCATE, 16'h0000);
		send_request(spfa_pkg::OP_ALLOCATE, 16'hFFFF);
		wait_idle();

		// limit below the watermark
		configure(16'd500, 16'd100);
		send_request(spfa_pkg::OP_ALLOCATE, 16'h0000);
		wait_idle();

		configure(16'd0, 16'd2);
		repeat (3) send_request(spfa_pkg::OP_ALLOCATE, 16'h0000);
		wait_idle();

		// fill the free list past its depth, then drain it into fresh grants
		tx_gaps = 1'($urandom_range(0, 1));
		rx_gaps = 1'($urandom_range(0, 1));
		configure(16'd0, 16'hFFFF);
		n_fill = POOL_DEPTH - pool.free_ports.size() + 6;
		repeat (n_fill) send_request(spfa_pkg::OP_RELEASE, pick_port());
		wait_idle();
		repeat (POOL_DEPTH + 4)
			send_request(spfa_pkg::OP_ALLOCATE, spfa_pkg::PORT_W'($urandom));
		wait_idle();

		foreach (pcts[i]) begin
			tx_gaps = (i == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_gaps = (i == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
			random_phase(20, pcts[i]);
		end

		if (pool.mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
